/* hw/rtl/wdt_pkg.sv */
`default_nettype none
package wdt_pkg;

	localparam int unsigned LOAD_BUSY_TICKS = 2;

	localparam logic [15:0] UNLOCK_KEY = 16'hE551;

	// control register bits
	localparam int unsigned CTL_INT_EN = 0;
	localparam int unsigned CTL_CNT_EN = 1;
	localparam int unsigned CTL_RST_EN = 3;

	// status register bits
	localparam int unsigned STS_IRQ  = 0;
	localparam int unsigned STS_RST  = 3;
	localparam int unsigned STS_BUSY = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		REG_LOAD_LO   = 4'd0,
		REG_LOAD_HI   = 4'd1,
		REG_CTRL      = 4'd2,
		REG_CLEAR     = 4'd3,
		REG_RAW_STS   = 4'd4,
		REG_MASK_STS  = 4'd5,
		REG_CNT_LO    = 4'd6,
		REG_CNT_HI    = 4'd7,
		REG_LOCK      = 4'd8,
		REG_CNT_LO_RD = 4'd9,
		REG_CNT_HI_RD = 4'd10,
		REG_PRE_LO    = 4'd11,
		REG_PRE_HI    = 4'd12,
		REG_UNUSED13  = 4'd13,
		REG_UNUSED14  = 4'd14,
		REG_UNUSED15  = 4'd15
	} reg_idx_t;

	typedef logic [$clog2(LOAD_BUSY_TICKS + 1) - 1:0] busy_cnt_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_out;
		logic        reset_pulse;
	} wdt_result_t;

	typedef struct packed {
		logic irq_status;
		logic reset_status;
		logic busy;
		logic cnt_zero;
	} wdt_status_t;

endpackage
`default_nettype wire

/* hw/rtl/wdt_core.sv */
`default_nettype none
module wdt_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wdt_pkg::op_t         op,
	input  wdt_pkg::reg_idx_t    idx,
	input  wire [15:0]           data,
	output wdt_pkg::wdt_result_t res,
	output wdt_pkg::wdt_status_t stat
);
	import wdt_pkg::*;

	logic [31:0] cnt_q, cnt_n, cnt_dec;
	logic [15:0] load_hi_q, load_hi_n;
	logic [15:0] pre_hi_q, pre_hi_n;
	logic [15:0] pre_lo_q, pre_lo_n;
	logic [3:0]  ctl_q, ctl_n;
	logic        irq_q, irq_n;
	logic        rst_q, rst_n;
	logic        unl_q, unl_n;
	busy_cnt_t   busy_q, busy_n;
	logic [15:0] rd;
	logic        pulse;

	assign cnt_dec = cnt_q - 32'd1;

	always_comb begin
		cnt_n     = cnt_q;
		load_hi_n = load_hi_q;
		pre_hi_n  = pre_hi_q;
		pre_lo_n  = pre_lo_q;
		ctl_n     = ctl_q;
		irq_n     = irq_q;
		rst_n     = rst_q;
		unl_n     = unl_q;
		busy_n    = busy_q;
		pulse     = 1'b0;
		rd        = 16'd0;
		case (op)
			OP_TICK: begin
				if (busy_q != '0) begin
					busy_n = busy_q - busy_cnt_t'(1);
				end
				if (ctl_q[CTL_CNT_EN]) begin
					// saturate at zero; latch reset on the one-to-zero step when reset is enabled
					if (cnt_q != 32'd0) begin
						cnt_n = cnt_dec;
						if (cnt_dec == 32'd0 && ctl_q[CTL_RST_EN]) begin
							rst_n = 1'b1;
							pulse = 1'b1;
						end
					end
					if (cnt_n == {pre_hi_q, pre_lo_q} && ctl_q[CTL_INT_EN]) begin
						irq_n = 1'b1;
					end
				end
			end
			OP_WRITE: begin
				if (idx == REG_LOCK) begin
					unl_n = (data == UNLOCK_KEY);
				end else if (unl_q) begin
					case (idx)
						REG_LOAD_LO: begin
							cnt_n  = {load_hi_q, data};
							busy_n = busy_cnt_t'(LOAD_BUSY_TICKS);
						end
						REG_LOAD_HI: load_hi_n = data;
						REG_CTRL:    ctl_n     = data[3:0];
						REG_CLEAR: begin
							if (data[STS_IRQ]) irq_n = 1'b0;
							if (data[STS_RST]) rst_n = 1'b0;
						end
						REG_PRE_LO:  pre_lo_n  = data;
						REG_PRE_HI:  pre_hi_n  = data;
						default: ;
					endcase
				end
			end
			OP_READ: begin
				case (idx)
					REG_LOAD_HI: rd = load_hi_q;
					REG_CTRL:    rd = {12'd0, ctl_q};
					REG_RAW_STS: begin
						rd[STS_IRQ]  = irq_q;
						rd[STS_RST]  = rst_q;
						rd[STS_BUSY] = (busy_q != '0);
					end
					REG_MASK_STS: begin
						rd[STS_IRQ] = irq_q & ctl_q[CTL_INT_EN];
						rd[STS_RST] = rst_q & ctl_q[CTL_RST_EN];
					end
					REG_CNT_LO, REG_CNT_LO_RD: rd = cnt_q[15:0];
					REG_CNT_HI, REG_CNT_HI_RD: rd = cnt_q[31:16];
					REG_LOCK:    rd = {15'd0, unl_q};
					REG_PRE_LO:  rd = pre_lo_q;
					REG_PRE_HI:  rd = pre_hi_q;
					default:     rd = 16'd0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			load_hi_q <= '0;
			pre_hi_q  <= '0;
			pre_lo_q  <= '0;
			ctl_q     <= '0;
			irq_q     <= 1'b0;
			rst_q     <= 1'b0;
			unl_q     <= 1'b0;
			busy_q    <= '0;
		end else if (en) begin
			cnt_q     <= cnt_n;
			load_hi_q <= load_hi_n;
			pre_hi_q  <= pre_hi_n;
			pre_lo_q  <= pre_lo_n;
			ctl_q     <= ctl_n;
			irq_q     <= irq_n;
			rst_q     <= rst_n;
			unl_q     <= unl_n;
			busy_q    <= busy_n;
		end
	end

	assign res.read_data   = rd;
	assign res.irq_out     = irq_n & ctl_n[CTL_INT_EN];
	assign res.reset_pulse = pulse;

	assign stat.irq_status   = irq_q;
	assign stat.reset_status = rst_q;
	assign stat.busy         = (busy_q != '0);
	assign stat.cnt_zero     = (cnt_q == 32'd0);

endmodule
`default_nettype wire

/* hw/rtl/watchdog_timer_with_pretimeout.sv */
// Path: a word accepted into the input register is processed into the result
//   register, which offers it on the output; while the output stalls, each
//   register holds its word.
// Throughput: one word per cycle while the output takes every word; the counter
//   update is a single 32-bit decrement and compare between the two registers.
//   A stalled result holds the input register, which then holds off the input.
// Reset: arst_n clears the counter, the watchdog registers, status and handshake
//   state; the held payload is not reset. The block comes out of reset locked
//   with all enables off.
`default_nettype none
module watchdog_timer_with_pretimeout (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [23:0] s_axis_tdata,  // [3:0] reg_index, [19:4] write_data, rest zero
	input  wire [1:0]  s_axis_tuser,  // [1:0] operation
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata  // [15:0] read_data, [16] irq_out, [17] reset_pulse
);
	import wdt_pkg::*;

	// input register
	logic        valid_s1;
	op_t         op_s1;
	reg_idx_t    idx_s1;
	logic [15:0] data_s1;

	// result register
	logic        out_valid_q;
	wdt_result_t res_q;

	wdt_result_t res;
	wdt_status_t stat;
	logic        advance;
	logic        in_acc;

	// Process the held word when the result register is free or being drained.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	// Take a new word whenever the input register is empty or empties this cycle.
	assign s_axis_tready = !valid_s1 || advance;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op_t'(s_axis_tuser);
			idx_s1  <= reg_idx_t'(s_axis_tdata[3:0]);
			data_s1 <= s_axis_tdata[19:4];
		end
	end

	// Watchdog state and register file; state commits only on advance.
	wdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (op_s1),
		.idx    (idx_s1),
		.data   (data_s1),
		.res    (res),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			// drop the word once taken
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.reset_pulse, res_q.irq_out, res_q.read_data};

	// A processed word always lands in the result register.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word did not reach the result register");

	// A held word that cannot advance stays in the input register.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held input word was lost");

	// A reset pulse leaves the reset status latched and the counter at zero.
	a_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.reset_pulse |=> stat.reset_status && stat.cnt_zero)
		else $error("reset pulse without latched status and zero counter");

	// An interrupt reported in a result is latched in the status.
	a_irq_latched: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.irq_out |=> stat.irq_status)
		else $error("interrupt reported without latched status");

	// A tick only ever counts load-busy down, never raises it.
	a_busy_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TICK && !stat.busy |=> !stat.busy)
		else $error("tick raised load-busy");

endmodule
`default_nettype wire
